@@ rtl/core/led_action_priority_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// LED action sequencer assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LED_ACTION_PRIORITY_SEQUENCER_ASSERT_SVH
`define LED_ACTION_PRIORITY_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// ante in one cycle implies cons in the same cycle
`define LAPSEQ_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lapseq assertion failed");

// ante in one cycle implies cons in the next cycle
`define LAPSEQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lapseq assertion failed");

// cond never holds
`define LAPSEQ_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lapseq assertion failed");

`else

`define LAPSEQ_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define LAPSEQ_ASSERT_NEXT(name, clk, rst, ante, cons)
`define LAPSEQ_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

@@ rtl/core/lapseq_pkg.sv @@
// ----------------------------------------------------------------------------
// LED action sequencer package
// Codes, action parameter types and the internal command format.
// ----------------------------------------------------------------------------
package lapseq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int DUR_W           = 32;

  localparam logic [2:0] EFF_OFF      = 3'd0;
  localparam logic [2:0] EFF_ON       = 3'd1;
  localparam logic [2:0] EFF_INACTIVE = 3'd5;

  localparam logic [1:0] LVL_LAMP     = 2'd0;
  localparam logic [1:0] LVL_OVERRIDE = 2'd1;
  localparam logic [1:0] LVL_LOCAL    = 2'd2;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_SUBMIT      = 3'd1;
  localparam logic [2:0] OP_OVERRIDE    = 3'd2;
  localparam logic [2:0] OP_LAMP        = 3'd3;
  localparam logic [2:0] OP_RESET_LOCAL = 3'd4;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_SUBMIT,
    CMD_OVERRIDE,
    CMD_LAMP,
    CMD_RESET_LOCAL,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]  effect;
    logic [7:0]  intensity;
    logic [15:0] period_ms;
    logic [15:0] on_ms;
  } led_params_t;

  typedef struct packed {
    cmd_kind_t        kind;
    led_params_t      params;
    logic [DUR_W-1:0] duration;
  } cmd_t;

  localparam int ENTRY_W = $bits(led_params_t) + DUR_W;

  // codes six and seven fold onto inactive
  function automatic logic [2:0] norm_effect(input logic [2:0] e);
    return (e > EFF_INACTIVE) ? EFF_INACTIVE : e;
  endfunction

endpackage

@@ rtl/core/lapseq_if.sv @@
// ----------------------------------------------------------------------------
// LED action sequencer channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface lapseq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [2:0]  effect;
  logic [7:0]  intensity;
  logic [15:0] period_ms;
  logic [15:0] on_ms;
  logic [31:0] duration;

  modport source (output valid, op, effect, intensity, period_ms, on_ms, duration,
                  input ready);
  modport sink   (input valid, op, effect, intensity, period_ms, on_ms, duration,
                  output ready);
endinterface

interface lapseq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_effect;
  logic [1:0]  out_level;
  logic [7:0]  out_intensity;
  logic [15:0] out_period_ms;
  logic [15:0] out_on_ms;
  logic [31:0] remaining;
  logic        dropped;
  logic [3:0]  queue_count;

  modport source (output valid, out_effect, out_level, out_intensity, out_period_ms,
                  out_on_ms, remaining, dropped, queue_count,
                  input ready);
  modport sink   (input valid, out_effect, out_level, out_intensity, out_period_ms,
                  out_on_ms, remaining, dropped, queue_count,
                  output ready);
endinterface

@@ rtl/core/lapseq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lapseq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/lapseq_front.sv @@
// ----------------------------------------------------------------------------
// LED action sequencer front end
// Accepts request transactions, decodes the op and normalises the effect.
// ----------------------------------------------------------------------------
module lapseq_front (
  input  logic              clk,
  input  logic              rst,
  lapseq_req_if.sink        req,
  output logic              cmd_valid,
  output lapseq_pkg::cmd_t  cmd,
  input  logic              cmd_ready
);
  import lapseq_pkg::*;

  logic      hold_valid;
  cmd_t      hold;
  cmd_kind_t kind_next;
  logic      take;

  always_comb begin
    unique case (req.op)
      OP_TICK:        kind_next = CMD_TICK;
      OP_SUBMIT:      kind_next = CMD_SUBMIT;
      OP_OVERRIDE:    kind_next = CMD_OVERRIDE;
      OP_LAMP:        kind_next = CMD_LAMP;
      OP_RESET_LOCAL: kind_next = CMD_RESET_LOCAL;
      default:        kind_next = CMD_NONE;
    endcase
  end

  assign req.ready = !hold_valid || cmd_ready;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold.kind             <= kind_next;
      hold.params.effect    <= norm_effect(req.effect);
      hold.params.intensity <= req.intensity;
      hold.params.period_ms <= req.period_ms;
      hold.params.on_ms     <= req.on_ms;
      hold.duration         <= req.duration;
    end
  end

  assign cmd_valid = hold_valid;
  assign cmd       = hold;

endmodule

@@ rtl/core/lapseq_cmdq.sv @@
// ----------------------------------------------------------------------------
// LED action sequencer command queue
// Two-entry FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module lapseq_cmdq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  lapseq_pkg::cmd_t  push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output lapseq_pkg::cmd_t  pop_data,
  input  logic              pop_ready
);
  import lapseq_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/lapseq_back.sv @@
// ----------------------------------------------------------------------------
// LED action sequencer back end
// Executes commands, runs the local FIFO pop loop and drives the response.
// ----------------------------------------------------------------------------
`include "led_action_priority_sequencer_assert.svh"

module lapseq_back #(
  parameter int QUEUE_DEPTH = lapseq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  lapseq_pkg::cmd_t  cmd,
  output logic              cmd_ready,
  lapseq_rsp_if.source      rsp
);
  import lapseq_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W:0]   SUM_WRAP = (FILL_W + 1)'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_LOAD, S_REPORT} state_t;

  state_t             state;
  logic [FILL_W-1:0]  fill;
  logic [PTR_W-1:0]   head;
  led_params_t        local_cur;
  logic [DUR_W-1:0]   local_left;
  led_params_t        ovr;
  logic [DUR_W-1:0]   lamp_left;
  logic               drop_flag;

  logic               rsp_valid;
  logic [2:0]         rsp_effect;
  logic [1:0]         rsp_level;
  logic [7:0]         rsp_intensity;
  logic [15:0]        rsp_period_ms;
  logic [15:0]        rsp_on_ms;
  logic [DUR_W-1:0]   rsp_remaining;
  logic               rsp_dropped;
  logic [3:0]         rsp_count;

  logic [FILL_W:0]    tail_sum;
  logic [PTR_W-1:0]   tail;
  logic               wr_en;
  logic [ENTRY_W-1:0] rd_entry;
  led_params_t        rd_params;
  logic [DUR_W-1:0]   rd_dur;

  led_params_t        act;
  logic [1:0]         act_level;
  logic [DUR_W-1:0]   act_rem;

  assign tail_sum = (FILL_W + 1)'(head) + (FILL_W + 1)'(fill);
  assign tail     = (tail_sum >= SUM_WRAP) ? PTR_W'(tail_sum - SUM_WRAP) : PTR_W'(tail_sum);

  assign cmd_ready = (state == S_IDLE);
  assign wr_en     = (state == S_IDLE) && cmd_valid && (cmd.kind == CMD_SUBMIT)
                     && (fill != FILL_MAX);

  // head is stable from S_POP into S_LOAD, so the registered read lines up
  lapseq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data ({cmd.params, cmd.duration}),
    .rd_addr (head),
    .rd_data (rd_entry)
  );

  assign {rd_params, rd_dur} = rd_entry;

  always_comb begin
    if (lamp_left != '0) begin
      act           = '0;
      act.effect    = EFF_ON;
      act_level     = LVL_LAMP;
      act_rem       = lamp_left;
    end else if (ovr.effect != EFF_INACTIVE) begin
      act           = ovr;
      act_level     = LVL_OVERRIDE;
      act_rem       = '1;
    end else begin
      act           = local_cur;
      act_level     = LVL_LOCAL;
      act_rem       = local_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      fill             <= '0;
      head             <= '0;
      local_cur        <= '{effect: EFF_OFF, default: '0};
      local_left       <= '0;
      ovr              <= '{effect: EFF_INACTIVE, default: '0};
      lamp_left        <= '0;
      drop_flag        <= 1'b0;
      rsp_valid        <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (state != S_REPORT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            drop_flag <= (cmd.kind == CMD_SUBMIT) && (fill == FILL_MAX);
            unique case (cmd.kind)
              CMD_TICK: begin
                if (local_left != '0) begin
                  local_left <= local_left - DUR_W'(1);
                end
                if (lamp_left != '0) begin
                  lamp_left <= lamp_left - DUR_W'(1);
                end
                state <= S_POP;
              end
              CMD_SUBMIT: begin
                if (fill != FILL_MAX) begin
                  fill <= fill + FILL_W'(1);
                end
                state <= S_POP;
              end
              CMD_OVERRIDE: begin
                ovr   <= cmd.params;
                state <= S_REPORT;
              end
              CMD_LAMP: begin
                lamp_left <= cmd.duration;
                state     <= S_REPORT;
              end
              CMD_RESET_LOCAL: begin
                fill       <= '0;
                head       <= '0;
                local_left <= '0;
                state      <= S_REPORT;
              end
              default: state <= S_REPORT;
            endcase
          end
        end
        S_POP: begin
          if ((local_left == '0) && (fill != '0)) begin
            state <= S_LOAD;
          end else begin
            state <= S_REPORT;
          end
        end
        S_LOAD: begin
          local_cur  <= rd_params;
          local_left <= rd_dur;
          head       <= (head == LAST_PTR) ? '0 : head + PTR_W'(1);
          fill       <= fill - FILL_W'(1);
          state      <= S_POP;
        end
        S_REPORT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid     <= 1'b1;
            rsp_effect    <= act.effect;
            rsp_level     <= act_level;
            rsp_intensity <= act.intensity;
            rsp_period_ms <= act.period_ms;
            rsp_on_ms     <= act.on_ms;
            rsp_remaining <= act_rem;
            rsp_dropped   <= drop_flag;
            rsp_count     <= 4'(fill);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.out_effect    = rsp_effect;
  assign rsp.out_level     = rsp_level;
  assign rsp.out_intensity = rsp_intensity;
  assign rsp.out_period_ms = rsp_period_ms;
  assign rsp.out_on_ms     = rsp_on_ms;
  assign rsp.remaining     = rsp_remaining;
  assign rsp.dropped       = rsp_dropped;
  assign rsp.queue_count   = rsp_count;

  `LAPSEQ_ASSERT_NEVER(a_fill_bound, clk, rst, fill > FILL_MAX)
  `LAPSEQ_ASSERT_IMPLY(a_load_needs_entry, clk, rst, state == S_LOAD,
                       (fill != '0) && (local_left == '0))
  `LAPSEQ_ASSERT_NEXT(a_load_consumes, clk, rst, state == S_LOAD,
                      fill == $past(fill) - FILL_W'(1))
  `LAPSEQ_ASSERT_NEXT(a_full_submit_drops, clk, rst,
                      (state == S_IDLE) && cmd_valid && (cmd.kind == CMD_SUBMIT)
                      && (fill == FILL_MAX), drop_flag && (fill == FILL_MAX))

endmodule

@@ rtl/core/led_action_priority_sequencer.sv @@
// ----------------------------------------------------------------------------
// LED action priority sequencer
// Chooses the LED action in force from lamp test, override and local queue.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction (tick, submit local, set override,
//   lamp test, reset local); rsp returns exactly one transaction per command
//   with the action now in force, its control level, the drop flag and the
//   number of local actions still queued.
//   Override, lamp test, reset local and unused ops go straight to the
//   report; tick and submit first pop 0 to QUEUE_DEPTH entries off the
//   local FIFO, where each pop costs one read of the local FIFO RAM plus
//   its load. The back end takes a new command only once it has reported
//   the last one; the front end and a two-entry command queue absorb up to
//   three further transactions meanwhile.
//   Reset (rst, synchronous) empties the local FIFO, sets local action off,
//   withdraws any override and ends any lamp test.
//   When rsp stalls the result is held in its output register; commands keep
//   being accepted until the queue ahead of the back end is full.
// ----------------------------------------------------------------------------
module led_action_priority_sequencer #(
  parameter int QUEUE_DEPTH = lapseq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lapseq_req_if.sink   req,
  lapseq_rsp_if.source rsp
);
  import lapseq_pkg::*;

  logic front_valid;
  cmd_t front_cmd;
  logic front_ready;
  logic back_valid;
  cmd_t back_cmd;
  logic back_ready;

  lapseq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (front_ready)
  );

  lapseq_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_data  (front_cmd),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_data   (back_cmd),
    .pop_ready  (back_ready)
  );

  lapseq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd       (back_cmd),
    .cmd_ready (back_ready),
    .rsp       (rsp)
  );

endmodule
